// ===== src/ps2m_pkg.sv =====
// Shared types, command codes and helpers for the PS/2 mouse host sequencer.
`default_nettype none

package ps2m_pkg;

   typedef enum logic [3:0] {
      STEP_IDLE       = 4'd0,
      STEP_DEFAULTS   = 4'd1,
      STEP_RATE_CMD_A = 4'd2,
      STEP_RATE_200   = 4'd3,
      STEP_RATE_CMD_B = 4'd4,
      STEP_RATE_100   = 4'd5,
      STEP_RATE_CMD_C = 4'd6,
      STEP_RATE_80    = 4'd7,
      STEP_GET_ID     = 4'd8,
      STEP_WAIT_ID    = 4'd9,
      STEP_ENABLE     = 4'd10,
      STEP_STREAM     = 4'd11,
      STEP_FAILED     = 4'd12
   } step_type;

   localparam logic [1:0] OP_START   = 2'd0;
   localparam logic [1:0] OP_RX_BYTE = 2'd1;
   localparam logic [1:0] OP_TICK    = 2'd2;

   localparam logic [1:0] STATUS_IDLE   = 2'd0;
   localparam logic [1:0] STATUS_BUSY   = 2'd1;
   localparam logic [1:0] STATUS_STREAM = 2'd2;
   localparam logic [1:0] STATUS_FAILED = 2'd3;

   localparam logic [7:0] CMD_SET_DEFAULTS = 8'hF6;
   localparam logic [7:0] CMD_SAMPLE_RATE  = 8'hF3;
   localparam logic [7:0] CMD_GET_ID       = 8'hF2;
   localparam logic [7:0] CMD_ENABLE       = 8'hF4;
   localparam logic [7:0] RATE_200         = 8'd200;
   localparam logic [7:0] RATE_100         = 8'd100;
   localparam logic [7:0] RATE_80          = 8'd80;
   localparam logic [7:0] REPLY_ACK        = 8'hFA;
   localparam logic [7:0] ID_WHEEL         = 8'h03;
   localparam logic [7:0] ID_WHEEL_5BTN    = 8'h04;
   localparam logic [7:0] SYNC_MASK        = 8'h08;
   localparam logic [7:0] OVERFLOW_MASK    = 8'hC0;

   localparam logic [19:0] TIMEOUT_RESET = 20'd200000;

   localparam int TDATA_W = 40;
   localparam int TUSER_W = 2;

   typedef struct packed {
      logic              left;
      logic              right;
      logic              middle;
      logic signed [7:0] move_x;
      logic signed [8:0] move_y;
      logic signed [7:0] wheel;
   } packet_type;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       packet_valid;
      packet_type pkt;
      logic [1:0] status;
      logic       wheel_mode;
   } result_type;

   // Byte sent to the mouse on entry to a step; zero means send nothing.
   function automatic logic [7:0] entry_byte(input step_type s);
      logic [7:0] b;
      unique case (s)
         STEP_DEFAULTS:   b = CMD_SET_DEFAULTS;
         STEP_RATE_CMD_A: b = CMD_SAMPLE_RATE;
         STEP_RATE_200:   b = RATE_200;
         STEP_RATE_CMD_B: b = CMD_SAMPLE_RATE;
         STEP_RATE_100:   b = RATE_100;
         STEP_RATE_CMD_C: b = CMD_SAMPLE_RATE;
         STEP_RATE_80:    b = RATE_80;
         STEP_GET_ID:     b = CMD_GET_ID;
         STEP_ENABLE:     b = CMD_ENABLE;
         default:         b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

// ===== src/ps2m_pkt_decode.sv =====
// Movement packet decoder: buttons, overflow gating, y negation and wheel.
`default_nettype none

module ps2m_pkt_decode (
   input  wire logic [7:0]          byte1,
   input  wire logic [7:0]          byte2_stored,
   input  wire logic [7:0]          rx_byte,
   input  wire logic                four_byte,
   input  wire logic [7:0]          first_byte,
   output ps2m_pkg::packet_type     pkt
);

   logic [7:0] y_byte;
   logic       overflow;

   // Third byte is the fresh one in three-byte mode.
   assign y_byte   = four_byte ? byte2_stored : rx_byte;
   assign overflow = (first_byte & ps2m_pkg::OVERFLOW_MASK) != 8'h00;

   always_comb begin
      pkt.left   = first_byte[0];
      pkt.right  = first_byte[1];
      pkt.middle = first_byte[2];
      pkt.move_x = overflow ? 8'sd0 : $signed(byte1);
      pkt.move_y = overflow ? 9'sd0 : $signed(9'd0 - {y_byte[7], y_byte});
      pkt.wheel  = four_byte ? $signed(rx_byte) : 8'sd0;
   end

endmodule

`default_nettype wire

// ===== src/ps2_mouse_host_sequencer_core.sv =====
// Each accepted request's response is registered in the output register, or in the skid slot when stalled.
// Throughput: one request per cycle; a two-entry output stage (register plus skid) lets a
//   request enter while one response still waits, and ready drops only when both are full.
// All set-up sequencing, timeout counting and packet framing is combinational next-state logic.
// Reset (synchronous, active high): step idle, byte position 0, three-byte mode, wait
//   counter 0, timeout limit 200000, output stage empty. Packet bytes are not cleared.
`default_nettype none

module ps2_mouse_host_sequencer_core (
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration: timeout_limit
   input  wire logic        csr_we,
   input  wire logic [19:0] csr_wdata,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  wire logic [1:0]  req_tuser,   // [1:0] op
   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [7:0] tx_byte, [8] button_left, [9] button_right, [10] button_middle,
   // [18:11] move_x, [27:19] move_y, [35:28] wheel_delta, [37:36] setup_status,
   // [38] wheel_mode, [39] zero
   output logic [ps2m_pkg::TDATA_W-1:0] rsp_tdata,
   output logic [ps2m_pkg::TUSER_W-1:0] rsp_tuser    // [0] tx_valid, [1] packet_valid
);

   // ------------------------------------------------------------------
   // State
   // ------------------------------------------------------------------
   ps2m_pkg::step_type step_ff, step_in;
   logic [1:0]         pos_ff, pos_in;
   logic               four_ff, four_in;
   logic [19:0]        wait_ff, wait_in;
   logic [19:0]        timeout_ff;
   logic [7:0]         store_ff [3];

   logic               store_we;
   logic [1:0]         store_idx;

   // Output stage
   logic                  out_valid_ff, skid_valid_ff;
   ps2m_pkg::result_type  out_data_ff, skid_data_ff;
   ps2m_pkg::result_type  result;

   logic accept;
   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;

   logic [1:0] op;
   logic [7:0] rx;
   assign op = req_tuser;
   assign rx = req_tdata;

   // ------------------------------------------------------------------
   // Packet decode
   // ------------------------------------------------------------------
   ps2m_pkg::packet_type pkt;

   ps2m_pkt_decode u_decode (
      .byte1        (store_ff[1]),
      .byte2_stored (store_ff[2]),
      .rx_byte      (rx),
      .four_byte    (four_ff),
      .first_byte   (store_ff[0]),
      .pkt          (pkt)
   );

   // ------------------------------------------------------------------
   // Sequencer next state and response
   // ------------------------------------------------------------------
   logic               waiting;
   logic               enter;
   ps2m_pkg::step_type enter_step;
   logic               fail;
   logic [19:0]        wait_inc;
   logic [2:0]         pos_plus;
   logic [2:0]         pkt_size;
   logic [7:0]         tx_b;

   assign waiting  = (step_ff >= ps2m_pkg::STEP_DEFAULTS) && (step_ff <= ps2m_pkg::STEP_ENABLE);
   assign wait_inc = wait_ff + 20'd1;
   assign pos_plus = {1'b0, pos_ff} + 3'd1;
   assign pkt_size = four_ff ? 3'd4 : 3'd3;

   always_comb begin
      step_in    = step_ff;
      pos_in     = pos_ff;
      four_in    = four_ff;
      wait_in    = wait_ff;
      store_we   = 1'b0;
      store_idx  = pos_ff;
      enter      = 1'b0;
      enter_step = step_ff;
      fail       = 1'b0;
      result     = '0;

      if (accept) begin
         unique case (op)
            ps2m_pkg::OP_START: begin
               pos_in     = 2'd0;
               four_in    = 1'b0;
               enter      = 1'b1;
               enter_step = ps2m_pkg::STEP_DEFAULTS;
            end
            ps2m_pkg::OP_RX_BYTE: begin
               if (step_ff == ps2m_pkg::STEP_STREAM) begin
                  // Drop a first byte without its sync bit.
                  if (pos_ff == 2'd0 && (rx & ps2m_pkg::SYNC_MASK) == 8'h00) begin
                     pos_in = pos_ff;
                  end else if (pos_plus < pkt_size) begin
                     store_we = 1'b1;
                     pos_in   = pos_plus[1:0];
                  end else begin
                     pos_in              = 2'd0;
                     result.packet_valid = 1'b1;
                     result.pkt          = pkt;
                  end
               end else if (step_ff == ps2m_pkg::STEP_WAIT_ID) begin
                  // Any byte here is the device ID.
                  four_in    = (rx == ps2m_pkg::ID_WHEEL) || (rx == ps2m_pkg::ID_WHEEL_5BTN);
                  enter      = 1'b1;
                  enter_step = ps2m_pkg::STEP_ENABLE;
               end else if (waiting) begin
                  if (rx == ps2m_pkg::REPLY_ACK) begin
                     enter = 1'b1;
                     if (step_ff == ps2m_pkg::STEP_ENABLE) begin
                        pos_in     = 2'd0;
                        enter_step = ps2m_pkg::STEP_STREAM;
                     end else begin
                        enter_step = ps2m_pkg::step_type'(step_ff + 4'd1);
                     end
                  end else begin
                     fail = 1'b1;
                  end
               end
            end
            ps2m_pkg::OP_TICK: begin
               if (waiting) begin
                  wait_in = wait_inc;
                  if (wait_inc >= timeout_ff) begin
                     fail = 1'b1;
                  end
               end
            end
            default: begin
               step_in = step_ff;
            end
         endcase

         // No ACK (wrong reply or timeout): wheel probe falls back, set-defaults or enable fails.
         if (fail) begin
            enter = 1'b1;
            if (step_ff >= ps2m_pkg::STEP_RATE_CMD_A && step_ff <= ps2m_pkg::STEP_WAIT_ID) begin
               four_in    = 1'b0;
               enter_step = ps2m_pkg::STEP_ENABLE;
            end else begin
               enter_step = ps2m_pkg::STEP_FAILED;
            end
         end

         // Enter a step: restart the reply timer and emit its command byte.
         tx_b = ps2m_pkg::entry_byte(enter_step);
         if (enter) begin
            step_in         = enter_step;
            wait_in         = 20'd0;
            result.tx_valid = tx_b != 8'h00;
            result.tx_byte  = tx_b;
         end

         priority if (step_in >= ps2m_pkg::STEP_DEFAULTS && step_in <= ps2m_pkg::STEP_ENABLE)
            result.status = ps2m_pkg::STATUS_BUSY;
         else if (step_in == ps2m_pkg::STEP_STREAM)
            result.status = ps2m_pkg::STATUS_STREAM;
         else if (step_in == ps2m_pkg::STEP_FAILED)
            result.status = ps2m_pkg::STATUS_FAILED;
         else
            result.status = ps2m_pkg::STATUS_IDLE;
         result.wheel_mode = four_in;
      end else begin
         tx_b = 8'h00;
      end
   end

   // ------------------------------------------------------------------
   // State registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff    <= ps2m_pkg::STEP_IDLE;
         pos_ff     <= 2'd0;
         four_ff    <= 1'b0;
         wait_ff    <= 20'd0;
         timeout_ff <= ps2m_pkg::TIMEOUT_RESET;
      end else begin
         step_ff <= step_in;
         pos_ff  <= pos_in;
         four_ff <= four_in;
         wait_ff <= wait_in;
         if (csr_we) begin
            timeout_ff <= csr_wdata;
         end
      end
   end

   // Packet bytes: every byte of a packet but the last, always written before they are read.
   always_ff @(posedge clock) begin
      if (store_we && store_idx != 2'd3) begin
         store_ff[store_idx] <= rx;
      end
   end

   // ------------------------------------------------------------------
   // Output stage: response register plus skid slot
   // ------------------------------------------------------------------
   logic out_free;
   assign out_free = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         // Advance: skid first, else the fresh response.
         out_valid_ff  <= skid_valid_ff || accept;
         skid_valid_ff <= 1'b0;
      end else if (accept) begin
         // Hold the stalled response, park the new one.
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : result;
      end
      if (!out_free && accept) begin
         skid_data_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = {out_data_ff.packet_valid, out_data_ff.tx_valid};
   assign rsp_tdata  = {1'b0,
                        out_data_ff.wheel_mode,
                        out_data_ff.status,
                        out_data_ff.pkt.wheel,
                        out_data_ff.pkt.move_y,
                        out_data_ff.pkt.move_x,
                        out_data_ff.pkt.middle,
                        out_data_ff.pkt.right,
                        out_data_ff.pkt.left,
                        out_data_ff.tx_byte};

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid slot holds a response while the output register is empty");

   a_tx_pkt_exclusive: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_data_ff.tx_valid && out_data_ff.packet_valid))
      else $error("command byte and packet in the same response");

   a_pkt_in_stream: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_data_ff.packet_valid) |->
         out_data_ff.status == ps2m_pkg::STATUS_STREAM)
      else $error("packet decoded outside streaming");

   a_pos_only_stream: assert property (@(posedge clock) disable iff (reset)
      (pos_ff != 2'd0) |-> step_ff == ps2m_pkg::STEP_STREAM)
      else $error("byte position advanced outside streaming");

   a_wheel_late_steps: assert property (@(posedge clock) disable iff (reset)
      four_ff |-> (step_ff == ps2m_pkg::STEP_ENABLE || step_ff == ps2m_pkg::STEP_STREAM ||
                   step_ff == ps2m_pkg::STEP_FAILED))
      else $error("wheel mode set before the device ID was read");

endmodule

`default_nettype wire
